// ===== hw/rtl/srnh_pkg.sv =====
// ----------------------------------------------------------------------------
// srnh_pkg
// Shared types and constants for the segment/rectangle nearest-hit pipeline.
// ----------------------------------------------------------------------------
package srnh_pkg;

	localparam int IN_W  = 256;
	localparam int OUT_W = 104;

	// unit length in Q1.14
	localparam logic signed [15:0] UNIT_POS = 16'sd16384;
	localparam logic signed [15:0] UNIT_NEG = -16'sd16384;

	// edge codes, in test order
	localparam logic [1:0] EDGE_TOP    = 2'd0;
	localparam logic [1:0] EDGE_LEFT   = 2'd1;
	localparam logic [1:0] EDGE_RIGHT  = 2'd2;
	localparam logic [1:0] EDGE_BOTTOM = 2'd3;
	localparam logic [1:0] EDGE_ORDER [4] = '{EDGE_TOP, EDGE_LEFT, EDGE_RIGHT, EDGE_BOTTOM};

	// iterative units: one step per pipeline stage
	localparam int DIV_E_STEPS = 32;
	localparam int DIV_N_STEPS = 16;
	localparam int SQ_W        = 64;
	localparam int SQ_STEPS    = SQ_W / 2;

	// one edge after setup
	typedef struct packed {
		logic                ok;
		logic                bneg;
		logic [31:0]         a;
		logic [31:0]         c;
		logic signed [31:0]  sb;
		logic signed [33:0]  lo;
		logic signed [33:0]  hi;
		logic signed [33:0]  ln;
	} edge_t;

	// one crossing candidate
	typedef struct packed {
		logic        ok;
		logic [31:0] a;
		logic [31:0] c;
		logic [31:0] hx;
		logic [31:0] hy;
		logic [1:0]  idx;
	} cand_t;

endpackage

// ===== hw/rtl/srnh_dly.sv =====
// ----------------------------------------------------------------------------
// srnh_dly
// Payload delay line that advances with the pipeline enable.
// ----------------------------------------------------------------------------
module srnh_dly #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] sr_q [D];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= d;
			for (int k = 1; k < D; k++) begin
				sr_q[k] <= sr_q[k-1];
			end
		end
	end

	assign q = sr_q[D-1];
endmodule

// ===== hw/rtl/srnh_div.sv =====
// ----------------------------------------------------------------------------
// srnh_div
// Pipelined restoring divider, one quotient bit per stage. The dividend bits
// above the quotient width must stay below the divisor.
// ----------------------------------------------------------------------------
module srnh_div #(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic [DW-1:0] rem
);
	logic [DW-1:0] r_s [1:QW];
	logic [QW-1:0] n_s [1:QW];
	logic [QW-1:0] q_s [1:QW];
	logic [DW-1:0] d_s [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW-1:0] r_in;
		logic [QW-1:0] n_in;
		logic [QW-1:0] q_in;
		logic [DW-1:0] d_in;
		logic [DW:0]   t;
		logic          ge;

		if (k == 0) begin : g_first
			assign r_in = DW'(num[NW-1:QW]);
			assign n_in = num[QW-1:0];
			assign q_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign r_in = r_s[k];
			assign n_in = n_s[k];
			assign q_in = q_s[k];
			assign d_in = d_s[k];
		end

		// bring down the next dividend bit, subtract when it fits
		assign t  = {r_in, n_in[QW-1]};
		assign ge = t >= {1'b0, d_in};

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k+1] <= ge ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
				n_s[k+1] <= n_in << 1;
				q_s[k+1] <= {q_in[QW-2:0], ge};
				d_s[k+1] <= d_in;
			end
		end
	end

	assign quo = q_s[QW];
	assign rem = r_s[QW];
endmodule

// ===== hw/rtl/srnh_sqrt.sv =====
// ----------------------------------------------------------------------------
// srnh_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module srnh_sqrt (
	input  logic                    clk,
	input  logic                    en,
	input  logic [srnh_pkg::SQ_W-1:0] rad,
	output logic [srnh_pkg::SQ_W/2-1:0] root
);
	import srnh_pkg::*;

	logic [SQ_W-1:0] v_s [1:SQ_STEPS];
	logic [SQ_W-1:0] r_s [1:SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
		logic [SQ_W-1:0] v_in;
		logic [SQ_W-1:0] r_in;
		logic [SQ_W-1:0] trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign v_in = rad;
			assign r_in = '0;
		end else begin : g_next
			assign v_in = v_s[k];
			assign r_in = r_s[k];
		end

		assign trial = r_in + BIT;
		assign ge    = v_in >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[k+1] <= ge ? v_in - trial : v_in;
				r_s[k+1] <= ge ? (r_in >> 1) + BIT : r_in >> 1;
			end
		end
	end

	assign root = r_s[SQ_STEPS][SQ_W/2-1:0];
endmodule

// ===== hw/rtl/segment_rectangle_nearest_hit.sv =====
// ----------------------------------------------------------------------------
// segment_rectangle_nearest_hit
// Nearest hit of a 2D segment against an axis-aligned rectangle, Q23.8.
// ----------------------------------------------------------------------------
// Each request on the s_ side carries one segment and one rectangle; the m_
// side returns one result per request, in order: hit flag, hit point and the
// outward face normal, or the unit direction when the start lies inside.
// A request accepted on s_ passes through every stage before its result is
// shown on m_; one request is taken every cycle while the output is not
// stalled. The latency is set by the square root (32 stages) and the normal
// divider (16 stages) chained on the inside path; the edge divider (32 stages)
// runs alongside them.
// Every stage shares one enable: while m_tvalid is high and m_tready low the
// whole pipeline holds and s_tready is low; otherwise it advances each cycle,
// and empty slots travel as bubbles. Reset clears all valid bits, so no result
// is shown until a request has passed through; no state links one request to
// the next.
// ----------------------------------------------------------------------------
module segment_rectangle_nearest_hit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// start_x, start_y, end_x, end_y, rect_left, rect_top, rect_width,
	// rect_height, zero pad
	input  logic [srnh_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// hit, hit_x, hit_y, normal_x, normal_y, zero pad
	output logic [srnh_pkg::OUT_W-1:0]  m_tdata
);
	import srnh_pkg::*;

	localparam int ST_DIVE = 3 + DIV_E_STEPS;
	localparam int ST_EDGE = ST_DIVE + 6;
	localparam int ST_LEN  = 4 + SQ_STEPS;
	localparam int ST_NUM  = ST_LEN + 1;
	localparam int ST_QN   = ST_NUM + DIV_N_STEPS;
	localparam int LAT     = ST_QN + 1;

	function automatic logic [33:0] mag34(input logic signed [33:0] v);
		mag34 = v[33] ? 34'(-v) : 34'(v);
	endfunction

	// pick the later candidate only when it is valid and the earlier is not, or it is strictly nearer
	function automatic cand_t pick(input cand_t ci, input cand_t cj,
			input logic [63:0] p_ij, input logic [63:0] p_ji);
		pick = (cj.ok && (!ci.ok || p_ji < p_ij)) ? cj : ci;
	endfunction

	logic           en;
	logic [LAT:1]   vld_s;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], s_tvalid};
		end
	end

	// stage 1: capture request
	logic signed [31:0] sx_s1, sy_s1, ex_s1, ey_s1, lf_s1, tp_s1;
	logic [30:0]        wd_s1, ht_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= s_tdata[31:0];
			sy_s1 <= s_tdata[63:32];
			ex_s1 <= s_tdata[95:64];
			ey_s1 <= s_tdata[127:96];
			lf_s1 <= s_tdata[159:128];
			tp_s1 <= s_tdata[191:160];
			wd_s1 <= s_tdata[222:192];
			ht_s1 <= s_tdata[253:223];
		end
	end

	// stage 2: edges, inside test, direction magnitudes
	logic signed [33:0] sx34, sy34, ex34, ey34, lf34, tp34, rt34, bt34, dx, dy;
	logic [33:0]        ax, ay;
	logic               halve;

	assign sx34  = 34'(sx_s1);
	assign sy34  = 34'(sy_s1);
	assign ex34  = 34'(ex_s1);
	assign ey34  = 34'(ey_s1);
	assign lf34  = 34'(lf_s1);
	assign tp34  = 34'(tp_s1);
	assign rt34  = lf34 + $signed({3'b000, wd_s1});
	assign bt34  = tp34 + $signed({3'b000, ht_s1});
	assign dx    = ex34 - sx34;
	assign dy    = ey34 - sy34;
	assign ax    = mag34(dx);
	assign ay    = mag34(dy);
	assign halve = ax[31] || ay[31];

	logic        inside_s2, negx_s2, negy_s2;
	logic [30:0] nax_s2, nay_s2;
	edge_t       ed_s2 [4];
	logic [31:0] b_s2 [4];

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s2 <= sx34 >= lf34 && sx34 < rt34 && sy34 >= tp34 && sy34 < bt34;
			negx_s2   <= dx[33];
			negy_s2   <= dy[33];
			nax_s2    <= halve ? ax[31:1] : ax[30:0];
			nay_s2    <= halve ? ay[31:1] : ay[30:0];
		end
	end

	// stage 3 onwards per edge
	logic [63:0] prod_s3 [4];
	edge_t       ed_s3 [4];
	edge_t       ed_s35 [4];
	logic [31:0] quo_s35 [4];
	logic [31:0] rem_s35 [4];
	edge_t       ed_s36 [4];
	logic [32:0] qr_s36 [4];
	cand_t       cand_s37 [4];

	for (genvar e = 0; e < 4; e++) begin : g_edge
		localparam logic [1:0] CODE = EDGE_ORDER[e];
		localparam bit HORIZ = (CODE == EDGE_TOP) || (CODE == EDGE_BOTTOM);
		logic signed [33:0] sa, ea, sb, eb, ln, lo, hi, mn, mx;
		logic [33:0]        da, dc, db;
		logic               rnd;
		logic signed [34:0] pos;
		edge_t              ed_n;

		if (HORIZ) begin : g_h
			assign sa = sy34;
			assign ea = ey34;
			assign sb = sx34;
			assign eb = ex34;
			assign lo = lf34;
			assign hi = rt34;
			assign ln = (CODE == EDGE_TOP) ? tp34 : bt34;
		end else begin : g_v
			assign sa = sx34;
			assign ea = ex34;
			assign sb = sy34;
			assign eb = ey34;
			assign lo = tp34;
			assign hi = bt34;
			assign ln = (CODE == EDGE_LEFT) ? lf34 : rt34;
		end

		assign mn = (sa < ea) ? sa : ea;
		assign mx = (sa < ea) ? ea : sa;
		assign da = mag34(ln - sa);
		assign dc = mag34(ea - sa);
		assign db = mag34(eb - sb);

		always_ff @(posedge clk) begin
			if (en) begin
				ed_s2[e].ok   <= hi > lo && ea != sa && ln >= mn && ln <= mx;
				ed_s2[e].bneg <= eb < sb;
				ed_s2[e].a    <= da[31:0];
				ed_s2[e].c    <= dc[31:0];
				ed_s2[e].sb   <= sb[31:0];
				ed_s2[e].lo   <= lo;
				ed_s2[e].hi   <= hi;
				ed_s2[e].ln   <= ln;
				b_s2[e]       <= db[31:0];
			end
		end

		// stage 3: offset product; crossing must lie before the end
		always_comb begin
			ed_n    = ed_s2[e];
			ed_n.ok = ed_s2[e].ok && ed_s2[e].a < ed_s2[e].c;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				prod_s3[e] <= 64'(ed_s2[e].a) * 64'(b_s2[e]);
				ed_s3[e]   <= ed_n;
			end
		end

		srnh_div #(.NW(64), .DW(32), .QW(DIV_E_STEPS)) u_div (
			.clk (clk),
			.en  (en),
			.num (prod_s3[e]),
			.den (ed_s3[e].c),
			.quo (quo_s35[e]),
			.rem (rem_s35[e])
		);

		srnh_dly #(.W($bits(edge_t)), .D(DIV_E_STEPS)) u_ed_dly (
			.clk (clk),
			.en  (en),
			.d   (ed_s3[e]),
			.q   (ed_s35[e])
		);

		// round half away from start
		assign rnd = {rem_s35[e], 1'b0} >= {1'b0, ed_s35[e].c};

		always_ff @(posedge clk) begin
			if (en) begin
				qr_s36[e] <= {1'b0, quo_s35[e]} + 33'(rnd);
				ed_s36[e] <= ed_s35[e];
			end
		end

		assign pos = ed_s36[e].bneg ? 35'(ed_s36[e].sb) - $signed({2'b00, qr_s36[e]})
		                            : 35'(ed_s36[e].sb) + $signed({2'b00, qr_s36[e]});

		always_ff @(posedge clk) begin
			if (en) begin
				cand_s37[e].ok  <= ed_s36[e].ok && pos >= ed_s36[e].lo && pos <= ed_s36[e].hi;
				cand_s37[e].a   <= ed_s36[e].a;
				cand_s37[e].c   <= ed_s36[e].c;
				cand_s37[e].hx  <= HORIZ ? pos[31:0] : ed_s36[e].ln[31:0];
				cand_s37[e].hy  <= HORIZ ? ed_s36[e].ln[31:0] : pos[31:0];
				cand_s37[e].idx <= CODE;
			end
		end
	end

	// nearest-crossing tournament, earlier edge wins a tie
	logic [63:0] pij_s38 [2];
	logic [63:0] pji_s38 [2];
	cand_t       cand_s38 [4];
	cand_t       win_s39 [2];

	for (genvar p = 0; p < 2; p++) begin : g_pair
		always_ff @(posedge clk) begin
			if (en) begin
				pij_s38[p]      <= 64'(cand_s37[2*p].a) * 64'(cand_s37[2*p+1].c);
				pji_s38[p]      <= 64'(cand_s37[2*p+1].a) * 64'(cand_s37[2*p].c);
				cand_s38[2*p]   <= cand_s37[2*p];
				cand_s38[2*p+1] <= cand_s37[2*p+1];
				win_s39[p]      <= pick(cand_s38[2*p], cand_s38[2*p+1],
				                        pij_s38[p], pji_s38[p]);
			end
		end
	end

	logic [63:0] pij_s40, pji_s40;
	cand_t       win_s40 [2];
	cand_t       fin_s41, fin_d;

	always_ff @(posedge clk) begin
		if (en) begin
			pij_s40    <= 64'(win_s39[0].a) * 64'(win_s39[1].c);
			pji_s40    <= 64'(win_s39[1].a) * 64'(win_s39[0].c);
			win_s40[0] <= win_s39[0];
			win_s40[1] <= win_s39[1];
			fin_s41    <= pick(win_s40[0], win_s40[1], pij_s40, pji_s40);
		end
	end

	srnh_dly #(.W($bits(cand_t)), .D(ST_QN - ST_EDGE)) u_fin_dly (
		.clk (clk),
		.en  (en),
		.d   (fin_s41),
		.q   (fin_d)
	);

	// direction normal: length, then both components over it
	logic [61:0] sqx_s3, sqy_s3;
	logic [63:0] sum_s4;
	logic [31:0] len_s36;
	logic [30:0] nax_d, nay_d;
	logic [45:0] numx_s37, numy_s37;
	logic [31:0] len_s37;
	logic        lenz_s37, lenz_d;
	logic [15:0] qx, qy;
	logic [31:0] unused_rx, unused_ry;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3 <= 62'(nax_s2) * 62'(nax_s2);
			sqy_s3 <= 62'(nay_s2) * 62'(nay_s2);
			sum_s4 <= 64'(sqx_s3) + 64'(sqy_s3);
		end
	end

	srnh_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sum_s4),
		.root (len_s36)
	);

	srnh_dly #(.W(62), .D(ST_LEN - 2)) u_na_dly (
		.clk (clk),
		.en  (en),
		.d   ({nax_s2, nay_s2}),
		.q   ({nax_d, nay_d})
	);

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s37 <= {1'b0, nax_d, 14'd0} + 46'(len_s36[31:1]);
			numy_s37 <= {1'b0, nay_d, 14'd0} + 46'(len_s36[31:1]);
			len_s37  <= len_s36;
			lenz_s37 <= len_s36 == '0;
		end
	end

	srnh_div #(.NW(46), .DW(32), .QW(DIV_N_STEPS)) u_divx (
		.clk (clk),
		.en  (en),
		.num (numx_s37),
		.den (len_s37),
		.quo (qx),
		.rem (unused_rx)
	);

	srnh_div #(.NW(46), .DW(32), .QW(DIV_N_STEPS)) u_divy (
		.clk (clk),
		.en  (en),
		.num (numy_s37),
		.den (len_s37),
		.quo (qy),
		.rem (unused_ry)
	);

	srnh_dly #(.W(1), .D(DIV_N_STEPS)) u_lenz_dly (
		.clk (clk),
		.en  (en),
		.d   (lenz_s37),
		.q   (lenz_d)
	);

	// start point and inside flags to the output stage
	logic        inside_d, negx_d, negy_d;
	logic [31:0] sx_d, sy_d;

	srnh_dly #(.W(3), .D(ST_QN - 2)) u_flag_dly (
		.clk (clk),
		.en  (en),
		.d   ({inside_s2, negx_s2, negy_s2}),
		.q   ({inside_d, negx_d, negy_d})
	);

	srnh_dly #(.W(64), .D(ST_QN - 1)) u_start_dly (
		.clk (clk),
		.en  (en),
		.d   ({sy_s1, sx_s1}),
		.q   ({sy_d, sx_d})
	);

	// output stage
	logic        hit_n;
	logic [31:0] hx_n, hy_n;
	logic [15:0] nx_n, ny_n;
	logic        hit_s54;
	logic [31:0] hx_s54, hy_s54;
	logic [15:0] nx_s54, ny_s54;

	always_comb begin
		hit_n = 1'b0;
		hx_n  = '0;
		hy_n  = '0;
		nx_n  = '0;
		ny_n  = '0;
		if (inside_d) begin
			hit_n = 1'b1;
			hx_n  = sx_d;
			hy_n  = sy_d;
			if (!lenz_d) begin
				nx_n = negx_d ? 16'(16'd0 - qx) : qx;
				ny_n = negy_d ? 16'(16'd0 - qy) : qy;
			end
		end else if (fin_d.ok) begin
			hit_n = 1'b1;
			hx_n  = fin_d.hx;
			hy_n  = fin_d.hy;
			unique case (fin_d.idx)
				EDGE_TOP:    ny_n = UNIT_NEG;
				EDGE_LEFT:   nx_n = UNIT_NEG;
				EDGE_RIGHT:  nx_n = UNIT_POS;
				EDGE_BOTTOM: ny_n = UNIT_POS;
				default:     nx_n = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s54 <= hit_n;
			hx_s54  <= hx_n;
			hy_s54  <= hy_n;
			nx_s54  <= nx_n;
			ny_s54  <= ny_n;
		end
	end

	assign m_tdata = {7'd0, ny_s54, nx_s54, hy_s54, hx_s54, hit_s54};

`ifndef NO_ASSERTIONS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[96:1] == '0)
		else $error("miss result carries non-zero payload");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[80:65]) >= UNIT_NEG && $signed(m_tdata[80:65]) <= UNIT_POS
			&& $signed(m_tdata[96:81]) >= UNIT_NEG && $signed(m_tdata[96:81]) <= UNIT_POS)
		else $error("normal component out of unit range");

	a_hit_flag: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[LAT-1] && (inside_d || fin_d.ok) |=> m_tvalid && m_tdata[0])
		else $error("hit lost at output stage");

	a_edge_norm: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[LAT-1] && !inside_d && fin_d.ok
			|=> (m_tdata[80:65] == '0) != (m_tdata[96:81] == '0))
		else $error("edge hit without a single axis normal");
`endif

endmodule

// ===== verif/segment_rectangle_nearest_hit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_rectangle_nearest_hit_tb
// Self-checking bench for the segment/rectangle nearest-hit pipeline.
// ----------------------------------------------------------------------------
// A short directed table runs first: inside starts, hits on each edge, a
// crossing exactly at the segment end, a corner tie, a collinear edge and
// the coordinate extremes. Random requests follow, mostly segments thrown at
// small rectangles so that every edge and the inside path are reached, with a
// share of unrestricted and extreme values. Results are compared by field,
// in request order, with typed-in or behaviourally predicted nearest hits.
// ----------------------------------------------------------------------------
module segment_rectangle_nearest_hit_tb;
	import srnh_pkg::*;

	typedef struct {
		logic signed [31:0] sx, sy, ex, ey, lf, tp;
		logic [30:0]        w, h;
	} seg_rect_t;

	typedef struct {
		logic               hit;
		logic signed [31:0] hx, hy;
		logic signed [15:0] nx, ny;
	} hit_res_t;

	typedef struct {
		seg_rect_t req;
		bit        fixed;  // expected result typed in below
		hit_res_t  res;
	} dir_row_t;

	localparam int N_RANDOM   = 1330;
	localparam int HOLD_LEN   = 300;
	localparam int IDLE_LIMIT = 5000;
	localparam int TAIL       = 60;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;

	hit_res_t pending_hits[$];
	dir_row_t dir_rows[$];
	int       errors    = 0;
	int       n_results = 0;
	bit       calm      = 1'b0;
	bit       held      = 1'b0;
	int       idle_cycles = 0;

	segment_rectangle_nearest_hit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------
	function automatic longint unsigned mag(input longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// crossing of the segment with an edge at ln on axis a, spanning [lo,hi] on b
	function automatic bit edge_crossing(input longint sa, ea, sb, eb, ln, lo, hi,
			output longint unsigned num, den, output longint along);
		longint          mn, mx;
		longint unsigned a, c, b, q, rem, prod;
		num = 0; den = 1; along = 0;
		if (hi <= lo || ea == sa) return 1'b0;
		mn = sa < ea ? sa : ea;
		mx = sa < ea ? ea : sa;
		if (ln < mn || ln > mx) return 1'b0;
		a = mag(ln - sa);
		c = mag(ea - sa);
		b = mag(eb - sb);
		prod = a * (b % c);
		q = a * (b / c) + prod / c;
		rem = prod % c;
		if (2 * rem >= c) q++;
		along = eb >= sb ? sb + longint'(q) : sb - longint'(q);
		if (along < lo || along > hi) return 1'b0;
		num = a;
		den = c;
		return 1'b1;
	endfunction

	function automatic hit_res_t nearest_hit(input seg_rect_t r);
		hit_res_t        res;
		longint          sx, sy, ex, ey, lf, tp, rt, bt, dx, dy, ln, along;
		longint unsigned ax, ay, len, mx, my, bn, bd, num, den;
		bit              horiz, ok;
		logic [1:0]      e;
		res = '{default: '0};
		sx = r.sx; sy = r.sy; ex = r.ex; ey = r.ey; lf = r.lf; tp = r.tp;
		rt = lf + longint'({1'b0, r.w});
		bt = tp + longint'({1'b0, r.h});
		if (sx >= lf && sx < rt && sy >= tp && sy < bt) begin
			dx = ex - sx;
			dy = ey - sy;
			ax = mag(dx);
			ay = mag(dy);
			while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
				ax >>= 1;
				ay >>= 1;
			end
			len = int_sqrt(ax * ax + ay * ay);
			if (len != 0) begin
				mx = (ax * 64'd16384 + len / 2) / len;
				my = (ay * 64'd16384 + len / 2) / len;
				res.nx = dx < 0 ? -longint'(mx) : longint'(mx);
				res.ny = dy < 0 ? -longint'(my) : longint'(my);
			end
			res.hit = 1'b1;
			res.hx  = sx;
			res.hy  = sy;
		end else begin
			bn = 1;
			bd = 1;
			for (int i = 0; i < 4; i++) begin
				e = EDGE_ORDER[i];
				horiz = (e == EDGE_TOP || e == EDGE_BOTTOM);
				ln = e == EDGE_TOP ? tp : e == EDGE_LEFT ? lf : e == EDGE_RIGHT ? rt : bt;
				if (horiz)
					ok = edge_crossing(sy, ey, sx, ex, ln, lf, rt, num, den, along);
				else
					ok = edge_crossing(sx, ex, sy, ey, ln, tp, bt, num, den, along);
				if (ok && num * bd < bn * den) begin
					bn = num;
					bd = den;
					res.hit = 1'b1;
					res.hx  = horiz ? along : ln;
					res.hy  = horiz ? ln : along;
					res.nx  = e == EDGE_LEFT ? UNIT_NEG : e == EDGE_RIGHT ? UNIT_POS : '0;
					res.ny  = e == EDGE_TOP ? UNIT_NEG : e == EDGE_BOTTOM ? UNIT_POS : '0;
				end
			end
		end
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic seg_rect_t mk_req(input int sx, sy, ex, ey, lf, tp,
			input logic [30:0] w, h);
		seg_rect_t r;
		r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey; r.lf = lf; r.tp = tp;
		r.w = w; r.h = h;
		return r;
	endfunction

	function automatic hit_res_t mk_res(input logic hit, input int hx, hy,
			input logic signed [15:0] nx, ny);
		hit_res_t r;
		r.hit = hit; r.hx = hx; r.hy = hy; r.nx = nx; r.ny = ny;
		return r;
	endfunction

	function automatic void add_row(input seg_rect_t req, input bit fixed,
			input hit_res_t res);
		dir_row_t d;
		d.req = req; d.fixed = fixed; d.res = res;
		dir_rows.insert(dir_rows.size(), d);
	endfunction

	function automatic int spread(input int base, input int span);
		return base + int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic [31:0] extreme32();
		case ($urandom_range(0, 3))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	function automatic seg_rect_t random_req();
		seg_rect_t r;
		int        kind, rl, rw, rh;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			r = mk_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				31'($urandom), 31'($urandom));
		end else if (kind < 20) begin
			r = mk_req(extreme32(), extreme32(), extreme32(), extreme32(), extreme32(),
				extreme32(), 31'(extreme32()), 31'(extreme32()));
		end else begin
			// small rectangle, segment thrown across or around it
			rw = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 16'h4000);
			rh = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 16'h4000);
			rl = spread(0, 20'h10000);
			r.lf = rl;
			r.tp = spread(0, 20'h10000);
			r.w  = 31'(rw);
			r.h  = 31'(rh);
			r.sx = spread(rl + rw / 2, rw / 2 + 16'h4000);
			r.sy = spread(r.tp + rh / 2, rh / 2 + 16'h4000);
			r.ex = spread(rl + rw / 2, rw / 2 + 16'h4000);
			r.ey = spread(r.tp + rh / 2, rh / 2 + 16'h4000);
			case ($urandom_range(0, 7))
				0: r.ex = r.sx;
				1: r.ey = r.sy;
				2: r.ex = $urandom_range(0, 1) ? rl : rl + rw;
				3: r.ey = $urandom_range(0, 1) ? r.tp : r.tp + rh;
				4: r.sx = $urandom_range(0, 1) ? rl : rl + rw;
				default: ;
			endcase
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------------
	task automatic offer(input seg_rect_t r, input hit_res_t res);
		if (!calm && $urandom_range(0, 99) < 35) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 35);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, r.h, r.w, r.tp, r.lf, r.ey, r.ex, r.sy, r.sx};
		do @(posedge clk); while (!s_tready);
		pending_hits.insert(pending_hits.size(), res);
	endtask

	initial begin
		seg_rect_t r;
		add_row(mk_req(32'h100, 32'h100, 32'h100, 32'h100, 0, 0, 31'h1000, 31'h1000),
			1, mk_res(1, 32'h100, 32'h100, 0, 0));
		add_row(mk_req(32'h100, 32'h100, 32'h800, 32'h100, 0, 0, 31'h1000, 31'h1000),
			1, mk_res(1, 32'h100, 32'h100, UNIT_POS, 0));
		add_row(mk_req(32'h100, 32'h100, 32'h100, 0, 0, 0, 31'h1000, 31'h1000),
			1, mk_res(1, 32'h100, 32'h100, 0, UNIT_NEG));
		add_row(mk_req(-32'h10000, -32'h10000, -32'h8000, -32'h10000, 0, 0,
			31'h1000, 31'h1000), 1, mk_res(0, 0, 0, 0, 0));
		add_row(mk_req(32'h800, -32'h1000, 32'h800, 32'h2000, 0, 0, 31'h1000, 31'h1000),
			1, mk_res(1, 32'h800, 0, 0, UNIT_NEG));
		add_row(mk_req(-32'h1000, 32'h800, 32'h2000, 32'h800, 0, 0, 31'h1000, 31'h1000),
			1, mk_res(1, 0, 32'h800, UNIT_NEG, 0));
		add_row(mk_req(32'h2000, 32'h800, -32'h1000, 32'h800, 0, 0, 31'h1000, 31'h1000),
			1, mk_res(1, 32'h1000, 32'h800, UNIT_POS, 0));
		add_row(mk_req(32'h800, 32'h2000, 32'h800, -32'h1000, 0, 0, 31'h1000, 31'h1000),
			1, mk_res(1, 32'h800, 32'h1000, 0, UNIT_POS));
		// edge reached only at the segment end: not kept
		add_row(mk_req(32'h800, -32'h1000, 32'h800, 0, 0, 0, 31'h1000, 31'h1000),
			1, mk_res(0, 0, 0, 0, 0));
		// start on the exclusive right edge
		add_row(mk_req(32'h1000, 32'h800, 32'h2000, 32'h800, 0, 0, 31'h1000, 31'h1000),
			0, '{default: '0});
		// through a corner: top and left tie
		add_row(mk_req(-32'h1000, -32'h1000, 32'h1000, 32'h1000, 0, 0,
			31'h1000, 31'h1000), 0, '{default: '0});
		// running along the top edge
		add_row(mk_req(-32'h1000, 0, 32'h2000, 0, 0, 0, 31'h1000, 31'h1000),
			0, '{default: '0});
		add_row(mk_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 0, '{default: '0});
		add_row(mk_req(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 0, '{default: '0});
		add_row(mk_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 0, '{default: '0});
		add_row(mk_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF), 0, '{default: '0});
		// zero-sized rectangle
		add_row(mk_req(-32'h1000, 0, 32'h1000, 0, 0, 0, 0, 0), 0, '{default: '0});
		add_row(mk_req(-32'h1000, 32'h10, 32'h1000, 32'h10, 0, 0, 0, 31'h100),
			0, '{default: '0});
		add_row(mk_req(32'h300, 32'h200, 32'h377, -32'h123, 0, 0, 31'h1000, 31'h1000),
			0, '{default: '0});
		add_row(mk_req(-32'h333, 32'h1FF, 32'h1555, 32'h7A1, 0, 0, 31'h1000, 31'h1000),
			0, '{default: '0});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].req,
				dir_rows[i].fixed ? dir_rows[i].res : nearest_hit(dir_rows[i].req));

		for (int n = 0; n < N_RANDOM; n++) begin
			calm = (n >= 400 && n < 650);
			if (n == 800) begin
				// drain the pipeline before carrying on
				s_tvalid <= 1'b0;
				while (pending_hits.size() != 0) @(posedge clk);
			end
			r = random_req();
			offer(r, nearest_hit(r));
		end
		s_tvalid <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------------
	// receiver and checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
		errors++;
	endtask

	initial begin
		hit_res_t want;
		int       hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				n_results++;
				if (pending_hits.size() == 0) begin
					report_mismatch("result with no request outstanding", 1, 0);
				end else begin
					want = pending_hits.pop_front();
					if (m_tdata[0] !== want.hit)
						report_mismatch("hit", m_tdata[0], want.hit);
					if (m_tdata[32:1] !== want.hx)
						report_mismatch("hit_x", m_tdata[32:1], want.hx);
					if (m_tdata[64:33] !== want.hy)
						report_mismatch("hit_y", m_tdata[64:33], want.hy);
					if (m_tdata[80:65] !== want.nx)
						report_mismatch("normal_x", m_tdata[80:65], want.nx);
					if (m_tdata[96:81] !== want.ny)
						report_mismatch("normal_y", m_tdata[96:81], want.ny);
				end
			end
			// hold off once for a long stretch so that the input backs up
			if (!held && n_results == 300) begin
				held = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || $urandom_range(0, 99) >= 35;
			end
		end
	end

	// advance the idle count; stop the run if nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[%0t] timeout: no request or result moved", $time);
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== files.f =====
hw/rtl/srnh_pkg.sv
hw/rtl/srnh_dly.sv
hw/rtl/srnh_div.sv
hw/rtl/srnh_sqrt.sv
hw/rtl/segment_rectangle_nearest_hit.sv
verif/segment_rectangle_nearest_hit_tb.sv
